// ===== sv/dsa_pkg.sv =====
// ============================================================================
// dsa_pkg
// Shared types, constants and functions for the slope and aspect stencil.
// ============================================================================
package dsa_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] CFG_INV_CELL     = 2'd2;

    localparam int CFG_W   = 24;
    localparam int INV_W   = 24;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int GRAD_W  = 32;
    localparam int CORD_W  = 36;
    localparam int ANGLE_W = 26;
    localparam int SLOPE_W = 15;
    localparam int ASPECT_W = 17;
    localparam int MIN_COUNT = 5;
    localparam int MAX_ROWS  = 4096;

    localparam logic signed [GRAD_W-1:0] GRAD_LIMIT = 32'sh7FFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 26'sd5898240;

    // atan(2^-i) in degrees, Q.16.
    localparam logic [22:0] ATAN_DEG_Q16 [24] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379, 23'd117304, 23'd58666, 23'd29335,
        23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115,
        23'd57, 23'd29, 23'd14, 23'd7,
        23'd4, 23'd2, 23'd1, 23'd0
    };

    // Position of a cell and the end-of-frame mark, carried down the pipe.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_cell_info;

    // CORDIC gain applied to a unit vector (1.0 in Q.16) after the given
    // number of vectoring steps.
    function automatic logic signed [CORD_W-1:0] unit_mag(int stages);
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] sx;
        logic signed [CORD_W-1:0] sy;
        x = 36'sd65536;
        y = '0;
        for (int i = 0; i < stages; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0) begin
                x = x + sx;
                y = y - sy;
            end else begin
                x = x - sx;
                y = y + sy;
            end
        end
        return x;
    endfunction

endpackage

// ===== sv/dsa_ram.sv =====
// ============================================================================
// dsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module dsa_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dsa_stencil.sv =====
// ============================================================================
// dsa_stencil
// Raster counters, line stores and 3x3 window; picks gradient differences.
// ============================================================================
module dsa_stencil #(
    parameter int MAX_COLUMNS    = 1024,
    parameter int ELEVATION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_accept,
    input  logic signed [ELEVATION_BITS-1:0] i_elevation,
    input  logic                           i_valid_flag,
    input  logic [10:0]                    i_column_count,
    input  logic [12:0]                    i_row_count,
    output logic                           o_valid,
    output logic signed [ELEVATION_BITS:0] o_diff_x,
    output logic                           o_half_x,
    output logic signed [ELEVATION_BITS:0] o_diff_y,
    output logic                           o_half_y,
    output dsa_pkg::t_cell_info            o_info
);

    localparam int EB = ELEVATION_BITS;
    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int EW = EB + 1;

    logic [AW-1:0]             r_col;
    logic [dsa_pkg::ROW_W-1:0] r_row;

    logic                r_s0_valid;
    logic [EW-1:0]       r_s0_cur;
    logic [AW-1:0]       r_s0_addr;
    logic                r_s0_emit;
    dsa_pkg::t_cell_info r_s0_info;

    logic [EW-1:0] r_w0_top;
    logic [EW-1:0] r_w0_mid;
    logic [EW-1:0] r_w0_cur;
    logic [EW-1:0] r_w1_mid;

    logic                r_s1_valid;
    logic signed [EW-1:0] r_diff_x;
    logic signed [EW-1:0] r_diff_y;
    logic                r_half_x;
    logic                r_half_y;
    dsa_pkg::t_cell_info r_s1_info;

    logic [2*EW-1:0] rd_data;
    logic [EW-1:0]   rd_top;
    logic [EW-1:0]   rd_mid;
    logic [13:0]     cols_sat;
    logic [13:0]     cols_m1;
    logic [12:0]     rows_sat;
    logic [11:0]     rows_m1;
    logic [13:0]     col_ext;
    logic            col_wrap;
    logic            row_wrap;
    logic            emit;
    logic [EW:0]     pick_x;
    logic [EW:0]     pick_y;

    // Returns {half, diff}: the difference to scale and whether to halve it.
    function automatic logic [EW:0] pick(logic [EW-1:0] lo, logic [EW-1:0] c,
                                         logic [EW-1:0] hi);
        logic signed [EW-1:0] elo;
        logic signed [EW-1:0] ec;
        logic signed [EW-1:0] ehi;
        logic [EW:0]          res;
        elo = {lo[EB-1], lo[EB-1:0]};
        ec  = {c[EB-1], c[EB-1:0]};
        ehi = {hi[EB-1], hi[EB-1:0]};
        if (!hi[EB]) begin
            if (!lo[EB]) begin
                res = '0;
            end else begin
                res = {1'b0, ec - elo};
            end
        end else if (!lo[EB]) begin
            res = {1'b0, ehi - ec};
        end else begin
            res = {1'b1, ehi - elo};
        end
        return res;
    endfunction

    always_comb begin
        if (i_column_count < 11'(dsa_pkg::MIN_COUNT)) begin
            cols_sat = 14'(dsa_pkg::MIN_COUNT);
        end else if ({3'b000, i_column_count} > 14'(MAX_COLUMNS)) begin
            cols_sat = 14'(MAX_COLUMNS);
        end else begin
            cols_sat = {3'b000, i_column_count};
        end
        if (i_row_count < 13'(dsa_pkg::MIN_COUNT)) begin
            rows_sat = 13'(dsa_pkg::MIN_COUNT);
        end else if (i_row_count > 13'(dsa_pkg::MAX_ROWS)) begin
            rows_sat = 13'(dsa_pkg::MAX_ROWS);
        end else begin
            rows_sat = i_row_count;
        end
        cols_m1 = cols_sat - 14'd1;
        rows_m1 = 12'(rows_sat - 13'd1);
    end

    assign col_ext  = 14'(r_col);
    assign col_wrap = col_ext >= cols_m1;
    assign row_wrap = r_row >= rows_m1;
    assign emit = (r_row >= 12'd2) && (col_ext >= 14'd2) && (r_row <= rows_m1)
                  && (col_ext <= cols_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s0_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_accept;
            if (i_accept) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : r_row + 12'd1;
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_accept) begin
            r_s0_cur       <= {i_valid_flag, i_elevation};
            r_s0_addr      <= r_col;
            r_s0_emit      <= emit;
            r_s0_info.row  <= r_row - 12'd1;
            r_s0_info.col  <= dsa_pkg::COL_W'(col_ext - 14'd1);
            r_s0_info.last <= (r_row == rows_m1) && (col_ext == cols_m1);
        end
    end

    // One RAM holds both line stores side by side: upper in the high half.
    dsa_ram #(
        .WIDTH (2 * EW),
        .DEPTH (MAX_COLUMNS)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (i_en && r_s0_valid),
        .i_waddr (r_s0_addr),
        .i_wdata ({rd_mid, r_s0_cur}),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    assign rd_top = rd_data[2*EW-1:EW];
    assign rd_mid = rd_data[EW-1:0];

    assign pick_x = pick(r_w1_mid, r_w0_mid, rd_mid);
    assign pick_y = pick(r_w0_top, r_w0_mid, r_w0_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0_top   <= '0;
            r_w0_mid   <= '0;
            r_w0_cur   <= '0;
            r_w1_mid   <= '0;
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= r_s0_valid && r_s0_emit;
            if (r_s0_valid) begin
                r_w1_mid <= r_w0_mid;
                r_w0_top <= rd_top;
                r_w0_mid <= rd_mid;
                r_w0_cur <= r_s0_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_s0_valid) begin
            r_diff_x  <= pick_x[EW-1:0];
            r_half_x  <= pick_x[EW];
            r_diff_y  <= pick_y[EW-1:0];
            r_half_y  <= pick_y[EW];
            r_s1_info <= r_s0_info;
        end
    end

    assign o_valid  = r_s1_valid;
    assign o_diff_x = r_diff_x;
    assign o_half_x = r_half_x;
    assign o_diff_y = r_diff_y;
    assign o_half_y = r_half_y;
    assign o_info   = r_s1_info;

endmodule

// ===== sv/dsa_gradient.sv =====
// ============================================================================
// dsa_gradient
// Scales the differences by the reciprocal cell size, halves and saturates.
// ============================================================================
module dsa_gradient #(
    parameter int ELEVATION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [ELEVATION_BITS:0]       i_diff_x,
    input  logic                                 i_half_x,
    input  logic signed [ELEVATION_BITS:0]       i_diff_y,
    input  logic                                 i_half_y,
    input  dsa_pkg::t_cell_info                  i_info,
    input  logic [dsa_pkg::INV_W-1:0]            i_inv,
    output logic                                 o_valid,
    output logic signed [dsa_pkg::GRAD_W-1:0]    o_dx,
    output logic signed [dsa_pkg::GRAD_W-1:0]    o_dy,
    output logic                                 o_zero,
    output dsa_pkg::t_cell_info                  o_info
);

    localparam int PW = ELEVATION_BITS + 1 + dsa_pkg::INV_W + 1;

    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic                 r_hx;
    logic                 r_hy;
    logic                 r_v2;
    dsa_pkg::t_cell_info  r_info2;

    logic signed [dsa_pkg::GRAD_W-1:0] r_dx;
    logic signed [dsa_pkg::GRAD_W-1:0] r_dy;
    logic                              r_zero;
    logic                              r_v3;
    dsa_pkg::t_cell_info               r_info3;

    logic signed [dsa_pkg::INV_W:0]    inv_s;
    logic signed [dsa_pkg::GRAD_W-1:0] gx;
    logic signed [dsa_pkg::GRAD_W-1:0] gy;

    function automatic logic signed [dsa_pkg::GRAD_W-1:0] finish(
        logic signed [PW-1:0] p, logic half);
        logic signed [PW-1:0] h;
        logic signed [PW-1:0] lim;
        logic signed [dsa_pkg::GRAD_W-1:0] res;
        lim = PW'(dsa_pkg::GRAD_LIMIT);
        // Halving truncates toward zero.
        h = half ? ((p + $signed(PW'(p[PW-1]))) >>> 1) : p;
        if (h > lim) begin
            res = dsa_pkg::GRAD_LIMIT;
        end else if (h < -lim) begin
            res = -dsa_pkg::GRAD_LIMIT;
        end else begin
            res = h[dsa_pkg::GRAD_W-1:0];
        end
        return res;
    endfunction

    assign inv_s = {1'b0, i_inv};
    assign gx = finish(r_px, r_hx);
    assign gy = finish(r_py, r_hy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= PW'(i_diff_x * inv_s);
            r_py    <= PW'(i_diff_y * inv_s);
            r_hx    <= i_half_x;
            r_hy    <= i_half_y;
            r_info2 <= i_info;
            r_dx    <= gx;
            r_dy    <= gy;
            r_zero  <= (gx == '0) && (gy == '0);
            r_info3 <= r_info2;
        end
    end

    assign o_valid = r_v3;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_zero  = r_zero;
    assign o_info  = r_info3;

endmodule

// ===== sv/dsa_cordic.sv =====
// ============================================================================
// dsa_cordic
// Pipelined CORDIC vectoring: quadrant fold, then one step per stage.
// ============================================================================
module dsa_cordic #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [dsa_pkg::CORD_W-1:0]    i_x,
    input  logic signed [dsa_pkg::CORD_W-1:0]    i_y,
    input  logic [SIDE_W-1:0]                    i_side,
    output logic                                 o_valid,
    output logic signed [dsa_pkg::CORD_W-1:0]    o_x,
    output logic signed [dsa_pkg::ANGLE_W-1:0]   o_z,
    output logic [SIDE_W-1:0]                    o_side
);

    logic signed [dsa_pkg::CORD_W-1:0]  r_x    [STAGES+1];
    logic signed [dsa_pkg::CORD_W-1:0]  r_y    [STAGES+1];
    logic signed [dsa_pkg::ANGLE_W-1:0] r_z    [STAGES+1];
    logic [SIDE_W-1:0]                  r_side [STAGES+1];
    logic                               r_v    [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // A vector in the left half plane is turned by a quarter turn first.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= dsa_pkg::QUARTER_TURN;
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -dsa_pkg::QUARTER_TURN;
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_step
        localparam logic signed [dsa_pkg::ANGLE_W-1:0] ANG =
            dsa_pkg::ANGLE_W'(dsa_pkg::ATAN_DEG_Q16[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[i+1] <= r_side[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ANG;
                end
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_x     = r_x[STAGES];
    assign o_z     = r_z[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

// ===== sv/dem_slope_aspect_stencil.sv =====
// ============================================================================
// dem_slope_aspect_stencil
// Slope and aspect of a streamed elevation raster over a 3x3 window.
// ============================================================================
// Usage: elevation samples with a validity flag enter in raster order on the
// input channel (i_valid, o_stall). For every interior cell one result
// request leaves on the output channel (o_valid, i_stall) with slope and
// aspect in Q8.8 degrees, the cell position and an end-of-frame mark.
// Border cells and the first two rows and columns of the window produce
// nothing. The block is a single pipeline with an output register at the end
// and accepts one sample in every cycle it is not stalled.
// From accepting the sample that completes a cell's window, the result passes
// one counter and line store read stage, one window stage, two gradient
// stages, two CORDIC pipes of CORDIC_STAGES+1 stages each (aspect and
// magnitude, then slope), and the output register. The throughput is one
// sample per clock while not stalled.
// When the receiver stalls while a result is held, the whole pipeline freezes
// and o_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears the counters, the window and all valid bits and
// loads the default configuration. The line stores are not cleared; a frame
// fills them before it reads them. Configuration writes take effect at once
// and must only be issued while the pipeline is empty.
// ============================================================================
module dem_slope_aspect_stencil #(
    parameter int MAX_COLUMNS    = 1024,
    parameter int ELEVATION_BITS = 16,
    parameter int CORDIC_STAGES  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [dsa_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ELEVATION_BITS-1:0]    i_elevation,
    input  logic                                i_valid_flag,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dsa_pkg::SLOPE_W-1:0]         o_slope_deg,
    output logic signed [dsa_pkg::ASPECT_W-1:0] o_aspect_deg,
    output logic [dsa_pkg::ROW_W-1:0]           o_cell_row,
    output logic [dsa_pkg::COL_W-1:0]           o_cell_column,
    output logic                                o_frame_last
);

    localparam int EW = ELEVATION_BITS + 1;
    localparam int INFO_W = $bits(dsa_pkg::t_cell_info);
    localparam int SIDE_A = INFO_W + 1;
    localparam int SIDE_S = INFO_W + 1 + dsa_pkg::ASPECT_W;
    localparam logic signed [dsa_pkg::CORD_W-1:0] UNIT_MAG =
        dsa_pkg::unit_mag(CORDIC_STAGES);

    // Configuration registers.
    logic [10:0]               r_column_count;
    logic [12:0]               r_row_count;
    logic [dsa_pkg::INV_W-1:0] r_inv_cell;

    // The pipeline advances whenever the output register can take a result.
    logic adv;
    logic in_accept;

    logic                 st_valid;
    logic signed [EW-1:0] st_diff_x;
    logic signed [EW-1:0] st_diff_y;
    logic                 st_half_x;
    logic                 st_half_y;
    dsa_pkg::t_cell_info  st_info;

    logic                              gr_valid;
    logic signed [dsa_pkg::GRAD_W-1:0] gr_dx;
    logic signed [dsa_pkg::GRAD_W-1:0] gr_dy;
    logic                              gr_zero;
    dsa_pkg::t_cell_info               gr_info;

    logic                               ca_valid;
    logic signed [dsa_pkg::CORD_W-1:0]  ca_mag;
    logic signed [dsa_pkg::ANGLE_W-1:0] ca_z;
    logic [SIDE_A-1:0]                  ca_side;

    logic                               cs_valid;
    logic signed [dsa_pkg::CORD_W-1:0]  cs_x;
    logic signed [dsa_pkg::ANGLE_W-1:0] cs_z;
    logic [SIDE_S-1:0]                  cs_side;

    logic signed [dsa_pkg::ANGLE_W-1:0] aspect_rnd;
    logic signed [dsa_pkg::ASPECT_W-1:0] aspect_q8;
    logic signed [dsa_pkg::ANGLE_W-1:0] slope_rnd;
    logic [dsa_pkg::SLOPE_W-1:0]        slope_q8;
    dsa_pkg::t_cell_info                fin_info;
    logic                               fin_zero;
    logic signed [dsa_pkg::ASPECT_W-1:0] fin_aspect;

    logic                                r_out_valid;
    logic [dsa_pkg::SLOPE_W-1:0]         r_slope;
    logic signed [dsa_pkg::ASPECT_W-1:0] r_aspect;
    dsa_pkg::t_cell_info                 r_out_info;

    assign adv       = !r_out_valid || !i_stall;
    assign o_stall   = !adv;
    assign in_accept = i_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= 11'd1024;
            r_row_count    <= 13'd1024;
            r_inv_cell     <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dsa_pkg::CFG_COLUMN_COUNT: r_column_count <= i_cfg_data[10:0];
                dsa_pkg::CFG_ROW_COUNT:    r_row_count    <= i_cfg_data[12:0];
                dsa_pkg::CFG_INV_CELL:     r_inv_cell     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsa_stencil #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .ELEVATION_BITS (ELEVATION_BITS)
    ) u_stencil (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_accept       (in_accept),
        .i_elevation    (i_elevation),
        .i_valid_flag   (i_valid_flag),
        .i_column_count (r_column_count),
        .i_row_count    (r_row_count),
        .o_valid        (st_valid),
        .o_diff_x       (st_diff_x),
        .o_half_x       (st_half_x),
        .o_diff_y       (st_diff_y),
        .o_half_y       (st_half_y),
        .o_info         (st_info)
    );

    dsa_gradient #(
        .ELEVATION_BITS (ELEVATION_BITS)
    ) u_gradient (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (st_valid),
        .i_diff_x (st_diff_x),
        .i_half_x (st_half_x),
        .i_diff_y (st_diff_y),
        .i_half_y (st_half_y),
        .i_info   (st_info),
        .i_inv    (r_inv_cell),
        .o_valid  (gr_valid),
        .o_dx     (gr_dx),
        .o_dy     (gr_dy),
        .o_zero   (gr_zero),
        .o_info   (gr_info)
    );

    // Aspect angle and gradient magnitude come out of the same CORDIC pass.
    dsa_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE_A)
    ) u_cordic_aspect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (gr_valid),
        .i_x     (dsa_pkg::CORD_W'(gr_dx)),
        .i_y     (dsa_pkg::CORD_W'(gr_dy)),
        .i_side  ({gr_zero, gr_info}),
        .o_valid (ca_valid),
        .o_x     (ca_mag),
        .o_z     (ca_z),
        .o_side  (ca_side)
    );

    // Round half up to Q.8 and clamp to +-180 degrees.
    always_comb begin
        aspect_rnd = (ca_z + 26'sd128) >>> 8;
        if (aspect_rnd < -26'sd46080) begin
            aspect_q8 = -17'sd46080;
        end else if (aspect_rnd > 26'sd46080) begin
            aspect_q8 = 17'sd46080;
        end else begin
            aspect_q8 = aspect_rnd[dsa_pkg::ASPECT_W-1:0];
        end
    end

    // The slope is the angle of (unit, magnitude); the unit vector carries
    // the same CORDIC gain so the ratio stays exact.
    dsa_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE_S)
    ) u_cordic_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (ca_valid),
        .i_x     (UNIT_MAG),
        .i_y     (ca_mag),
        .i_side  ({aspect_q8, ca_side}),
        .o_valid (cs_valid),
        .o_x     (cs_x),
        .o_z     (cs_z),
        .o_side  (cs_side)
    );

    assign fin_info   = cs_side[INFO_W-1:0];
    assign fin_zero   = cs_side[INFO_W];
    assign fin_aspect = cs_side[SIDE_S-1:INFO_W+1];

    always_comb begin
        slope_rnd = (cs_z + 26'sd128) >>> 8;
        if (slope_rnd < 0) begin
            slope_q8 = '0;
        end else if (slope_rnd > 26'sd23040) begin
            slope_q8 = 15'd23040;
        end else begin
            slope_q8 = slope_rnd[dsa_pkg::SLOPE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= cs_valid;
        end
    end

    // A flat cell reports zero slope and zero aspect.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_slope    <= fin_zero ? '0 : slope_q8;
            r_aspect   <= fin_zero ? '0 : fin_aspect;
            r_out_info <= fin_info;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_slope_deg   = r_slope;
    assign o_aspect_deg  = r_aspect;
    assign o_cell_row    = r_out_info.row;
    assign o_cell_column = r_out_info.col;
    assign o_frame_last  = r_out_info.last;

    // The slope magnitude path must never see a left half plane vector.
    a_mag_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ca_valid && adv) |-> (ca_mag >= 0))
        else $error("gradient magnitude negative");

    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slope_deg <= 15'd23040))
        else $error("slope out of range");

    a_aspect_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_aspect_deg <= 17'sd46080) && (o_aspect_deg >= -17'sd46080)))
        else $error("aspect out of range");

    a_interior_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_cell_row != '0) && (o_cell_column != '0)))
        else $error("result for a border cell");

    // Unused magnitude of the slope pass stays positive, never zero.
    a_slope_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cs_valid |-> (cs_x > 0))
        else $error("slope CORDIC lost its gain");

endmodule

// ===== sim/tb_dem_slope_aspect_stencil.sv =====
// ============================================================================
// tb_dem_slope_aspect_stencil
// Self-checking testbench for the slope and aspect stencil.
// ============================================================================
// Elevation frames are streamed into the block in raster order. A predictor
// inside the testbench keeps its own line stores, window and counters. For
// every accepted sample it advances and, for an interior cell, computes the
// expected slope, aspect and cell position. A checker compares each result
// request with the oldest pending expectation, field by field. Configuration
// changes happen only at frame boundaries, after the pipeline has drained.
// Unwritten line store entries are therefore never read for a result. Both
// channels idle at random, except in the closing part of the run.
// ============================================================================
module tb_dem_slope_aspect_stencil;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL        = 1024;
    localparam int STAGES      = 16;
    localparam int DRAIN       = 2 * STAGES + 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [dsa_pkg::SLOPE_W-1:0]  slope;
        logic [dsa_pkg::ASPECT_W-1:0] aspect;
        logic [dsa_pkg::ROW_W-1:0]    row;
        logic [dsa_pkg::COL_W-1:0]    col;
        logic                         last;
    } t_cell_angles;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [1:0]                          i_cfg_index;
    logic [dsa_pkg::CFG_W-1:0]           i_cfg_data;
    logic                                i_valid;
    logic                                o_stall;
    logic signed [15:0]                  i_elevation;
    logic                                i_valid_flag;
    logic                                o_valid;
    logic                                i_stall;
    logic [dsa_pkg::SLOPE_W-1:0]         o_slope_deg;
    logic signed [dsa_pkg::ASPECT_W-1:0] o_aspect_deg;
    logic [dsa_pkg::ROW_W-1:0]           o_cell_row;
    logic [dsa_pkg::COL_W-1:0]           o_cell_column;
    logic                                o_frame_last;

    dem_slope_aspect_stencil uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_elevation   (i_elevation),
        .i_valid_flag  (i_valid_flag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_slope_deg   (o_slope_deg),
        .o_aspect_deg  (o_aspect_deg),
        .o_cell_row    (o_cell_row),
        .o_cell_column (o_cell_column),
        .o_frame_last  (o_frame_last)
    );

    // Predictor state: line stores hold {valid, elevation} per column.
    logic [16:0]  upper_line [NCOL];
    logic [16:0]  middle_line [NCOL];
    logic [16:0]  win [2][3];
    int unsigned  row_ctr;
    int unsigned  col_ctr;
    logic [10:0]  cols_reg;
    logic [12:0]  rows_reg;
    logic [23:0]  inv_reg;

    t_cell_angles pending_angles[$];
    int           mismatches;
    int           samples_sent;
    int           cycle_count;
    bit           idle_on;
    int           stall_left;

    // atan(2^-i) in degrees, Q.16.
    const longint atan_q16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint height(logic [16:0] e);
        return longint'($signed(e[15:0]));
    endfunction

    // Central difference halves toward zero; one-sided uses the valid side.
    function automatic longint slope_term(logic [16:0] lo, logic [16:0] c,
                                          logic [16:0] hi, longint inv);
        longint n;
        if (!hi[16]) begin
            if (!lo[16]) return 0;
            n = (height(c) - height(lo)) * inv;
        end else if (!lo[16]) begin
            n = (height(hi) - height(c)) * inv;
        end else begin
            n = ((height(hi) - height(lo)) * inv) / 2;
        end
        if (n > 64'sd2147483647) n = 64'sd2147483647;
        if (n < -64'sd2147483647) n = -64'sd2147483647;
        return n;
    endfunction

    // Vectoring rotation: returns the angle in Q.16 degrees, magnitude in mag.
    function automatic longint vector_angle(longint x, longint y, output longint mag);
        longint z;
        longint t;
        longint sx;
        longint sy;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 90 * 65536;
            end else begin
                x = -y;
                y = t;
                z = -90 * 65536;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0) begin
                x += sx;
                y -= sy;
                z += atan_q16[i];
            end else begin
                x -= sx;
                y += sy;
                z -= atan_q16[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint round_q8(longint z, longint lo, longint hi);
        longint r;
        r = (z + 128) >>> 8;
        if (r < lo) return lo;
        if (r > hi) return hi;
        return r;
    endfunction

    // Advance the predictor by one accepted sample.
    task automatic predict_sample(logic signed [15:0] e, logic f);
        int unsigned  cols;
        int unsigned  rows;
        logic [16:0]  cur;
        logic [16:0]  top;
        logic [16:0]  mid;
        longint       dx;
        longint       dy;
        longint       m;
        longint       u;
        longint       slope;
        longint       aspect;
        t_cell_angles exp_res;
        cols = cols_reg;
        rows = rows_reg;
        if (cols < 5) cols = 5;
        if (cols > NCOL) cols = NCOL;
        if (rows < 5) rows = 5;
        if (rows > 4096) rows = 4096;
        cur = {f, e};
        top = upper_line[col_ctr];
        mid = middle_line[col_ctr];
        upper_line[col_ctr] = mid;
        middle_line[col_ctr] = cur;

        if (row_ctr >= 2 && col_ctr >= 2 && row_ctr <= rows - 1 && col_ctr <= cols - 1) begin
            dx = slope_term(win[1][1], win[0][1], mid, longint'(inv_reg));
            dy = slope_term(win[0][0], win[0][1], win[0][2], longint'(inv_reg));
            slope = 0;
            aspect = 0;
            if (dx != 0 || dy != 0) begin
                aspect = round_q8(vector_angle(dx, dy, m), -46080, 46080);
                void'(vector_angle(65536, 0, u));
                slope = round_q8(vector_angle(u, m, u), 0, 23040);
            end
            exp_res.slope  = slope[dsa_pkg::SLOPE_W-1:0];
            exp_res.aspect = aspect[dsa_pkg::ASPECT_W-1:0];
            exp_res.row    = dsa_pkg::ROW_W'(row_ctr - 1);
            exp_res.col    = dsa_pkg::COL_W'(col_ctr - 1);
            exp_res.last   = (row_ctr == rows - 1 && col_ctr == cols - 1);
            pending_angles = {pending_angles, exp_res};
        end

        win[1] = win[0];
        win[0][0] = top;
        win[0][1] = mid;
        win[0][2] = cur;

        if (col_ctr >= cols - 1) begin
            col_ctr = 0;
            row_ctr = (row_ctr >= rows - 1) ? 0 : row_ctr + 1;
        end else begin
            col_ctr++;
        end
    endtask

    // Offer one sample and hold it until the block takes it.
    task automatic send_sample(logic signed [15:0] e, logic f);
        i_valid      <= 1'b1;
        i_elevation  <= e;
        i_valid_flag <= f;
        do @(posedge i_clk); while (o_stall);
        predict_sample(e, f);
        samples_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Writes wait until every pending result is out and the pipe has drained.
    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dsa_pkg::CFG_COLUMN_COUNT: cols_reg = data[10:0];
            dsa_pkg::CFG_ROW_COUNT:    rows_reg = data[12:0];
            dsa_pkg::CFG_INV_CELL:     inv_reg  = data;
            default: ;
        endcase
    endtask

    task automatic set_frame(logic [10:0] c, logic [12:0] r, logic [23:0] inv);
        write_reg(dsa_pkg::CFG_COLUMN_COUNT, 24'(c));
        write_reg(dsa_pkg::CFG_ROW_COUNT, 24'(r));
        write_reg(dsa_pkg::CFG_INV_CELL, inv);
    endtask

    // Random elevation: mostly gentle terrain, sometimes full-range cliffs.
    function automatic logic signed [15:0] pick_height(logic signed [15:0] base);
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return 16'sh7FFF;
            2:       return -16'sh8000;
            default: return base + 16'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Streams whole frames so the counters end at the start of a frame.
    task automatic send_frame(int permille_invalid);
        int unsigned cols;
        int unsigned rows;
        logic signed [15:0] base;
        cols = (cols_reg < 5) ? 5 : (cols_reg > NCOL) ? NCOL : cols_reg;
        rows = (rows_reg < 5) ? 5 : (rows_reg > 4096) ? 4096 : rows_reg;
        base = 16'($urandom);
        for (int n = 0; n < cols * rows; n++) begin
            send_sample(pick_height(base), $urandom_range(0, 999) >= permille_invalid);
        end
    endtask

    // A 5x5 frame with full-scale steps, one-sided and missing neighbors.
    task automatic test_directed_frame();
        logic signed [15:0] hts [25];
        logic               flg [25];
        hts = '{-16'sh8000, 16'sh7FFF, 16'sd0, 16'sd100, 16'sd100,
                16'sh7FFF, -16'sh8000, 16'sd7, 16'sd100, -16'sd1,
                16'sd0, 16'sd5, 16'sd9, 16'sd100, 16'sd100,
                16'sd1, -16'sd300, 16'sd4, 16'sd100, 16'sd100,
                16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2};
        flg = '{1, 1, 1, 1, 1,
                1, 1, 1, 0, 1,
                1, 0, 0, 1, 0,
                1, 1, 1, 0, 1,
                1, 1, 1, 1, 0};
        set_frame(11'd5, 13'd5, 24'd65536);
        for (int n = 0; n < 25; n++) send_sample(hts[n], flg[n]);
    endtask

    // Counts below range, zero and full-scale reciprocals.
    task automatic test_count_limits();
        set_frame(11'd0, 13'd0, 24'd0);
        send_frame(100);
        set_frame(11'd5, 13'd5, 24'hFFFFFF);
        send_frame(50);
        set_frame(11'd6, 13'd5, 24'd1);
        send_frame(50);
    endtask

    task automatic test_random_frames();
        int start;
        start = samples_sent;
        while (samples_sent - start < 400) begin
            if (samples_sent - start > 300) idle_on = 1'b0;
            set_frame(11'($urandom_range(5, 12)), 13'($urandom_range(5, 9)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                      24'($urandom_range(1, 262144)));
            send_frame($urandom_range(0, 1) ? 0 : $urandom_range(0, 400));
        end
    endtask

    // Receiver stall bursts.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(1, 17);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_cell_angles exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: row %0d col %0d", o_cell_row, o_cell_column);
            end else begin
                exp_res = pending_angles.pop_front();
                if (o_slope_deg !== exp_res.slope || o_aspect_deg !== exp_res.aspect ||
                    o_cell_row !== exp_res.row || o_cell_column !== exp_res.col ||
                    o_frame_last !== exp_res.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected slope %0d aspect %0d r%0d c%0d ",
                                  "last %0b, got slope %0d aspect %0d r%0d c%0d last %0b"},
                                 exp_res.slope, $signed(exp_res.aspect), exp_res.row,
                                 exp_res.col, exp_res.last, o_slope_deg, o_aspect_deg,
                                 o_cell_row, o_cell_column, o_frame_last);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL dem_slope_aspect_stencil");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = dsa_pkg::CFG_COLUMN_COUNT;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_elevation  = '0;
        i_valid_flag = 1'b0;
        i_stall      = 1'b0;
        stall_left   = 0;
        mismatches   = 0;
        samples_sent = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        row_ctr      = 0;
        col_ctr      = 0;
        cols_reg     = 11'd1024;
        rows_reg     = 13'd1024;
        inv_reg      = 24'd65536;
        win          = '{default: '0};
        foreach (upper_line[k]) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frame();
        test_count_limits();
        test_random_frames();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("PASS dem_slope_aspect_stencil");
        end else begin
            $display("FAIL dem_slope_aspect_stencil");
        end
        $finish;
    end

endmodule
